// File: rtl/masked_event_trace_ring_defines.svh
// Assertion macros used by the trace ring RTL (mtr_ctrl).
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef MASKED_EVENT_TRACE_RING_DEFINES_SVH
`define MASKED_EVENT_TRACE_RING_DEFINES_SVH
`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define MTR_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion on the usual clk_i and rst_ni of the module.
`define MTR_ASSERT(name, prop, msg) \
  `MTR_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)
`else
`define MTR_ASSERT_CLK(name, clk, rstn, prop, msg)
`define MTR_ASSERT(name, prop, msg)
`endif
`endif

// File: rtl/mtr_pkg.sv
// Shared types and constants of the masked event trace ring.
// Depends on nothing; imported by every module of the block.
package mtr_pkg;

  localparam int unsigned RingDepthDefault = 256;
  localparam int unsigned MaskWidth        = 32;
  localparam int unsigned FillMax          = 255;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } mtr_action_e;

  // One stored trace record.
  typedef struct packed {
    logic [31:0] time_stamp;
    logic [31:0] value;
    logic [15:0] aux;
    logic [7:0]  index;
    logic [7:0]  kind;
  } mtr_rec_t;

  // Memory requests from the pointer control to the record store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mtr_mem_ctl_t;

  // Per-word status reported with every result.
  typedef struct packed {
    logic        accepted;
    logic        pop_valid;
    logic [7:0]  fill_level;
    logic [31:0] dropped_total;
  } mtr_status_t;

endpackage

// File: rtl/mtr_store.sv
// Record memory of the trace ring: one write port, one registered read port.
// Depends on mtr_pkg for the record type.
module mtr_store import mtr_pkg::*; #(
  parameter int unsigned RING_DEPTH = RingDepthDefault,
  parameter int unsigned PTR_W      = $clog2(RING_DEPTH)
) (
  input  logic             clk_i,
  input  mtr_mem_ctl_t     mem_ctl_i,
  input  logic [PTR_W-1:0] wr_addr_i,
  input  mtr_rec_t         wr_data_i,
  input  logic [PTR_W-1:0] rd_addr_i,
  output mtr_rec_t         rd_data_o
);

  mtr_rec_t mem_q [RING_DEPTH];
  mtr_rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data only moves on a pop, so it holds while the result waits.
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/mtr_ctrl.sv
// Pointer, fill count, drop counter and enable mask control of the trace ring.
// Depends on mtr_pkg and on masked_event_trace_ring_defines.svh for assertions.
`include "masked_event_trace_ring_defines.svh"
module mtr_ctrl import mtr_pkg::*; #(
  parameter int unsigned RING_DEPTH = RingDepthDefault,
  parameter int unsigned PTR_W      = $clog2(RING_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  logic [1:0]           action_i,
  input  logic [7:0]           event_kind_i,
  input  logic                 mask_we_i,
  input  logic [MaskWidth-1:0] mask_wdata_i,
  output mtr_mem_ctl_t         mem_ctl_o,
  output logic [PTR_W-1:0]     wr_ptr_o,
  output logic [PTR_W-1:0]     rd_ptr_o,
  output mtr_status_t          status_o
);

  localparam logic [PTR_W-1:0] LastSlot = PTR_W'(RING_DEPTH - 1);

  logic [MaskWidth-1:0] mask_q;
  logic [PTR_W-1:0]     wp_q, wp_d, rp_q, rp_d, cnt_q, cnt_d;
  logic [31:0]          drop_q, drop_d;
  logic                 enabled, full, empty;
  logic [31:0]          cnt_ext;

  // Kinds 32 and above have no mask bit and are never enabled.
  assign enabled = (event_kind_i[7:5] == 3'd0) && mask_q[event_kind_i[4:0]];
  assign full    = (cnt_q == LastSlot);
  assign empty   = (cnt_q == '0);

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    mem_ctl_o = '0;
    status_o  = '0;
    if (step_en_i) begin
      case (action_i)
        ACT_PUSH: begin
          if (enabled) begin
            if (full) begin
              drop_d = drop_q + 32'd1;
            end else begin
              mem_ctl_o.wr_en   = 1'b1;
              status_o.accepted = 1'b1;
              wp_d  = (wp_q == LastSlot) ? '0 : wp_q + 1'b1;
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
        ACT_POP: begin
          if (!empty) begin
            mem_ctl_o.rd_en    = 1'b1;
            status_o.pop_valid = 1'b1;
            rp_d  = (rp_q == LastSlot) ? '0 : rp_q + 1'b1;
            cnt_d = cnt_q - 1'b1;
          end
        end
        ACT_CLEAR: begin
          wp_d   = '0;
          rp_d   = '0;
          cnt_d  = '0;
          drop_d = '0;
        end
        default: begin
        end
      endcase
    end
    cnt_ext                = 32'(cnt_d);
    status_o.fill_level    = (cnt_ext > 32'(FillMax)) ? 8'(FillMax) : cnt_ext[7:0];
    status_o.dropped_total = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
      drop_q <= '0;
      mask_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
      if (mask_we_i) begin
        mask_q <= mask_wdata_i;
      end
    end
  end

  assign wr_ptr_o = wp_q;
  assign rd_ptr_o = rp_q;

  `MTR_ASSERT(a_cnt_bound, (cnt_q <= LastSlot), "fill count beyond ring capacity")
  `MTR_ASSERT(a_empty_ptrs, ((cnt_q == '0) == (wp_q == rp_q)), "fill count disagrees with pointers")
  `MTR_ASSERT(a_idle_stable, (!step_en_i |=> ($stable(wp_q) && $stable(rp_q) && $stable(drop_q))), "ring state moved without a word")
  `MTR_ASSERT(a_clear, ((step_en_i && action_i == ACT_CLEAR) |=> (cnt_q == '0 && drop_q == 32'd0 && wp_q == '0)), "clear left state behind")

endmodule

// File: rtl/masked_event_trace_ring.sv
// Top level of the masked event trace ring: handshakes and result register.
// Depends on mtr_pkg, mtr_ctrl and mtr_store.
//
// Usage. Each input word carries an action (push, pop or clear) and the event
// fields; a push is kept only when the bit of its kind is set in the enable
// mask. The user must write the mask (enable_mask_we_i / enable_mask_i) only
// while the block is idle; the block does not enforce it. Every accepted word
// yields exactly one result word on the output channel, carrying the accepted
// and pop_valid flags, the popped record (all zero unless the pop returned a
// record), fill level and total of pushes dropped because the ring was full.
// The result is valid in the cycle after acceptance. One word is taken every
// cycle while the receiver takes results; the figure is set by the single
// registered read port of the record memory, whose read data doubles as the
// result register for the record fields.
// A full ring holds RING_DEPTH - 1 records. When the receiver stalls, the
// result register holds and in_ready_o falls until it is taken; a word can be
// accepted in the same cycle the waiting result leaves.
// Reset clears the pointers, fill count, drop counter and enable mask. The
// record memory is not cleared; only slots already written are ever read.
module masked_event_trace_ring import mtr_pkg::*; #(
  parameter int unsigned RING_DEPTH = RingDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [7:0]           event_kind_i,
  input  logic [7:0]           event_index_i,
  input  logic [15:0]          event_aux_i,
  input  logic [31:0]          event_value_i,
  input  logic [31:0]          timestamp_i,
  input  logic                 enable_mask_we_i,
  input  logic [MaskWidth-1:0] enable_mask_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 accepted_o,
  output logic                 pop_valid_o,
  output logic [31:0]          out_time_o,
  output logic [7:0]           out_kind_o,
  output logic [7:0]           out_index_o,
  output logic [15:0]          out_aux_o,
  output logic [31:0]          out_value_o,
  output logic [7:0]           fill_level_o,
  output logic [31:0]          dropped_total_o
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);

  logic            step_en;
  logic            out_valid_q;
  mtr_status_t     status, status_q;
  mtr_mem_ctl_t    mem_ctl;
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  mtr_rec_t        wr_rec, rd_rec;

  // The result register may take a new word whenever it is empty or its
  // current word is being taken in this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step_en    = in_valid_i && in_ready_o;

  assign wr_rec.time_stamp = timestamp_i;
  assign wr_rec.value      = event_value_i;
  assign wr_rec.aux        = event_aux_i;
  assign wr_rec.index      = event_index_i;
  assign wr_rec.kind       = event_kind_i;

  mtr_ctrl #(
    .RING_DEPTH(RING_DEPTH),
    .PTR_W     (PtrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .action_i    (action_i),
    .event_kind_i(event_kind_i),
    .mask_we_i   (enable_mask_we_i),
    .mask_wdata_i(enable_mask_i),
    .mem_ctl_o   (mem_ctl),
    .wr_ptr_o    (wr_ptr),
    .rd_ptr_o    (rd_ptr),
    .status_o    (status)
  );

  mtr_store #(
    .RING_DEPTH(RING_DEPTH),
    .PTR_W     (PtrW)
  ) u_store (
    .clk_i    (clk_i),
    .mem_ctl_i(mem_ctl),
    .wr_addr_i(wr_ptr),
    .wr_data_i(wr_rec),
    .rd_addr_i(rd_ptr),
    .rd_data_o(rd_rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= '0;
    end else begin
      if (step_en) begin
        out_valid_q <= 1'b1;
        status_q    <= status;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Record fields read as zero on every word that is not a successful pop.
  assign out_valid_o     = out_valid_q;
  assign accepted_o      = status_q.accepted;
  assign pop_valid_o     = status_q.pop_valid;
  assign out_time_o      = status_q.pop_valid ? rd_rec.time_stamp : 32'd0;
  assign out_kind_o      = status_q.pop_valid ? rd_rec.kind : 8'd0;
  assign out_index_o     = status_q.pop_valid ? rd_rec.index : 8'd0;
  assign out_aux_o       = status_q.pop_valid ? rd_rec.aux : 16'd0;
  assign out_value_o     = status_q.pop_valid ? rd_rec.value : 32'd0;
  assign fill_level_o    = status_q.fill_level;
  assign dropped_total_o = status_q.dropped_total;

endmodule
